// ----- rtl/core/hnpg_pkg.sv -----
package hnpg_pkg;

    localparam int unsigned COORD_W     = 8;
    localparam int unsigned COORD_RANGE = 1 << COORD_W;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CHAN_W      = 8;

    localparam int unsigned TEXTURE_SIZE_DEFAULT = 256;

    // Coordinate spreading multipliers and the two lowbias32 mixing constants.
    localparam logic [WORD_W-1:0] MUL_X = 32'd374761393;
    localparam logic [WORD_W-1:0] MUL_Y = 32'd668265263;
    localparam logic [WORD_W-1:0] MIX_A = 32'h7feb352d;
    localparam logic [WORD_W-1:0] MIX_B = 32'h846ca68b;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Pipeline depth of the base stage and of one mixing lane.
    localparam int unsigned BASE_LATENCY = 2;
    localparam int unsigned MIX_LATENCY  = 3;

    typedef logic [COORD_W-1:0] wrap_lut_t [COORD_RANGE];

    // Builds the coordinate wrap table with a running counter, so no
    // division is needed even for texture sizes that are not a power of two.
    function automatic wrap_lut_t build_wrap_lut(input int unsigned size);
        wrap_lut_t   lut;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < COORD_RANGE; i++)
        begin
            lut[i] = COORD_W'(r);
            r = r + 1;
            if (r >= size)
            begin
                r = 0;
            end
        end
        return lut;
    endfunction

endpackage

// ----- rtl/core/hnpg_base.sv -----
module hnpg_base #(
    parameter int unsigned TEXTURE_SIZE = hnpg_pkg::TEXTURE_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [hnpg_pkg::COORD_W-1:0]    coord_x,
    input  logic [hnpg_pkg::COORD_W-1:0]    coord_y,
    input  logic [hnpg_pkg::WORD_W-1:0]     noise_seed,
    output logic                            out_valid,
    output logic [hnpg_pkg::WORD_W-1:0]     base
);

    localparam hnpg_pkg::wrap_lut_t WRAP_LUT = hnpg_pkg::build_wrap_lut(TEXTURE_SIZE);

    logic [hnpg_pkg::COORD_W-1:0] x_wrapped;
    logic [hnpg_pkg::COORD_W-1:0] y_wrapped;

    logic                         valid_a_reg;
    logic [hnpg_pkg::WORD_W-1:0]  prod_x_reg;
    logic [hnpg_pkg::WORD_W-1:0]  prod_x_next;
    logic [hnpg_pkg::WORD_W-1:0]  prod_y_reg;
    logic [hnpg_pkg::WORD_W-1:0]  prod_y_next;

    logic                         valid_b_reg;
    logic [hnpg_pkg::WORD_W-1:0]  base_reg;
    logic [hnpg_pkg::WORD_W-1:0]  base_next;

    // Stage A: wrap the coordinates into the texture and spread them.
    assign x_wrapped   = WRAP_LUT[coord_x];
    assign y_wrapped   = WRAP_LUT[coord_y];
    assign prod_x_next = hnpg_pkg::WORD_W'(hnpg_pkg::WORD_W'(x_wrapped) * hnpg_pkg::MUL_X);
    assign prod_y_next = hnpg_pkg::WORD_W'(hnpg_pkg::WORD_W'(y_wrapped) * hnpg_pkg::MUL_Y);

    // Stage B: fold in the seed.
    assign base_next = noise_seed ^ prod_x_reg ^ prod_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        base_reg   <= base_next;
    end

    assign out_valid = valid_b_reg;
    assign base      = base_reg;

endmodule

// ----- rtl/core/hnpg_mix.sv -----
module hnpg_mix (
    input  logic                            clk,
    input  logic [hnpg_pkg::WORD_W-1:0]     value_in,
    output logic [hnpg_pkg::CHAN_W-1:0]     chan_out
);

    logic [hnpg_pkg::WORD_W-1:0] shift_reg;
    logic [hnpg_pkg::WORD_W-1:0] shift_next;
    logic [hnpg_pkg::WORD_W-1:0] mul_a_reg;
    logic [hnpg_pkg::WORD_W-1:0] mul_a_next;
    logic [hnpg_pkg::WORD_W-1:0] mul_b_reg;
    logic [hnpg_pkg::WORD_W-1:0] mul_b_next;

    assign shift_next = value_in ^ (value_in >> 16);
    assign mul_a_next = hnpg_pkg::WORD_W'(shift_reg * hnpg_pkg::MIX_A);
    assign mul_b_next = hnpg_pkg::WORD_W'((mul_a_reg ^ (mul_a_reg >> 15)) * hnpg_pkg::MIX_B);

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
    end

    // Only the low byte of the final xor-shift is kept.
    assign chan_out = mul_b_reg[7:0] ^ mul_b_reg[23:16];

endmodule

// ----- rtl/core/hash_noise_pixel_generator_core.sv -----
// Hash noise pixel generator.
// An item is a pixel coordinate pair (coord_x, coord_y). It is accepted at a rising
// clock edge where start is high and busy is low; busy is always low, so the block
// takes one item in every cycle. Each item yields one packed RGBA word on
// pixel_word, marked by pixel_valid for exactly one cycle. The red, green and
// blue bytes come from a lowbias32-style hash of base, base+1 and base+2, where
// base is the seed XOR the two spread coordinates; alpha is always 0xFF.
// Throughput is one item per cycle, set by a fully pipelined datapath: two base
// stages (coordinate multiply, seed fold), three stages in each of three parallel
// mixing lanes (one 32x32 multiply per stage at most) and the output register.
// The receiver cannot stall; results are presented once and never held. Reset
// clears all valid bits and sets the seed to zero. The seed is written through
// cfg_write_en and cfg_write_data; the user must write it only while no items
// are in flight, which the block itself leaves unchecked.
module hash_noise_pixel_generator_core #(
    parameter int unsigned TEXTURE_SIZE = hnpg_pkg::TEXTURE_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [hnpg_pkg::WORD_W-1:0]     cfg_write_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [hnpg_pkg::COORD_W-1:0]    coord_x,
    input  logic [hnpg_pkg::COORD_W-1:0]    coord_y,
    output logic                            pixel_valid,
    output logic [hnpg_pkg::WORD_W-1:0]     pixel_word
);

    localparam int unsigned TOTAL_LATENCY =
        hnpg_pkg::BASE_LATENCY + hnpg_pkg::MIX_LATENCY + 1;

    logic [hnpg_pkg::WORD_W-1:0]        noise_seed_reg;
    logic                               accept;

    logic                               base_valid;
    logic [hnpg_pkg::WORD_W-1:0]        base;
    logic [hnpg_pkg::WORD_W-1:0]        base_plus_one;
    logic [hnpg_pkg::WORD_W-1:0]        base_plus_two;

    logic [hnpg_pkg::CHAN_W-1:0]        red;
    logic [hnpg_pkg::CHAN_W-1:0]        green;
    logic [hnpg_pkg::CHAN_W-1:0]        blue;

    logic [hnpg_pkg::MIX_LATENCY-1:0]   mix_valid_reg;
    logic [hnpg_pkg::MIX_LATENCY-1:0]   mix_valid_next;
    logic                               pixel_valid_reg;
    logic [hnpg_pkg::WORD_W-1:0]        pixel_word_reg;
    logic [hnpg_pkg::WORD_W-1:0]        pixel_word_next;

    // The pipeline never stalls, so the block is always ready for a new item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The user must write the seed only while the pipe is empty; nothing checks it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            noise_seed_reg <= cfg_write_data;
        end
    end

    hnpg_base #(
        .TEXTURE_SIZE (TEXTURE_SIZE)
    ) u_base (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .noise_seed (noise_seed_reg),
        .out_valid  (base_valid),
        .base       (base)
    );

    // The three channels hash neighboring base words in parallel lanes.
    assign base_plus_one = base + hnpg_pkg::WORD_W'(1);
    assign base_plus_two = base + hnpg_pkg::WORD_W'(2);

    hnpg_mix u_mix_red (
        .clk      (clk),
        .value_in (base),
        .chan_out (red)
    );

    hnpg_mix u_mix_green (
        .clk      (clk),
        .value_in (base_plus_one),
        .chan_out (green)
    );

    hnpg_mix u_mix_blue (
        .clk      (clk),
        .value_in (base_plus_two),
        .chan_out (blue)
    );

    // Valid bits follow the data through the mixing lanes.
    assign mix_valid_next  = {mix_valid_reg[hnpg_pkg::MIX_LATENCY-2:0], base_valid};
    assign pixel_word_next = {hnpg_pkg::ALPHA_OPAQUE, blue, green, red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg   <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            mix_valid_reg   <= mix_valid_next;
            pixel_valid_reg <= mix_valid_reg[hnpg_pkg::MIX_LATENCY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_word_reg <= pixel_word_next;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_word  = pixel_word_reg;

    // Every accepted item comes out exactly after the pipeline latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LATENCY pixel_valid)
    else $error("accepted item did not appear after the pipeline latency");

    // No result appears without an item accepted one latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##TOTAL_LATENCY !pixel_valid)
    else $error("result appeared without a matching accepted item");

    // A delivered pixel is always opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> pixel_word[31:24] == hnpg_pkg::ALPHA_OPAQUE)
    else $error("delivered pixel has a wrong alpha byte");

endmodule
